FILE: rtl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types, codes and constants for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

    // Default buffer limit; the top level overrides it by parameter.
    localparam int MAX_BUFFER_BYTES_DEF = 65535;

    // Width of a buffer length as carried between modules.
    localparam int LEN_W = 16;

    // Header layout (byte positions, network order)
    localparam int POS_VER_IHL   = 0;
    localparam int POS_TLEN_HI   = 2;
    localparam int POS_TLEN_LO   = 3;
    localparam int POS_FRAG_HI   = 6;
    localparam int POS_FRAG_LO   = 7;
    localparam int POS_PROTO     = 9;
    localparam int POS_SRC_FIRST = 12;
    localparam int POS_DST_FIRST = 16;
    localparam int POS_DST_END   = 20;

    localparam int MIN_HDR_BYTES = 20;

    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [3:0]  IHL_MIN      = 4'd5;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
    localparam logic [15:0] FRAG_MASK    = 16'h3FFF;

    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    // Verdict codes
    localparam logic [2:0]  V_ACCEPT     = 3'd0;
    localparam logic [2:0]  V_TOO_SHORT  = 3'd1;
    localparam logic [2:0]  V_BAD_HDR    = 3'd2;
    localparam logic [2:0]  V_BAD_LEN    = 3'd3;
    localparam logic [2:0]  V_BAD_SUM    = 3'd4;
    localparam logic [2:0]  V_FRAGMENT   = 3'd5;

    // Delivery codes
    localparam logic [1:0]  DLV_NONE     = 2'd0;
    localparam logic [1:0]  DLV_ICMP     = 2'd1;
    localparam logic [1:0]  DLV_UDP      = 2'd2;
    localparam logic [1:0]  DLV_TCP      = 2'd3;

    // Header state as it stands after the current byte
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       version_ihl;
        logic [15:0]      total_length;
        logic [15:0]      fragment_word;
        logic [7:0]       proto_byte;
        logic [31:0]      src_word;
        logic [31:0]      dst_word;
        logic [15:0]      ones_sum;
    } t_hdr;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  deliver_to;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
    } t_result;

endpackage

FILE: rtl/ihc_if.sv
// ----------------------------------------------------------------------------
// ihc_if
// Valid/ready channels of the IPv4 header checker: byte stream in, verdict out.
// ----------------------------------------------------------------------------
interface ihc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [1:0]  deliver_to;
    logic [7:0]  protocol;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;

    modport source (output valid, output verdict, output deliver_to, output protocol,
                    output source_addr, output dest_addr, output header_bytes,
                    output payload_bytes, input ready);
    modport sink   (input valid, input verdict, input deliver_to, input protocol,
                    input source_addr, input dest_addr, input header_bytes,
                    input payload_bytes, output ready);
endinterface

FILE: rtl/ipv4_header_checker_unit.sv
// ----------------------------------------------------------------------------
// ipv4_header_checker_unit
// Streams a received IPv4 buffer byte by byte and gives one verdict per buffer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                    Transfer moves
//  i_in     in   data_byte[7:0], last_byte                  one buffer byte
//  o_out    out  verdict, deliver_to, protocol, addresses,   one verdict per
//                header_bytes, payload_bytes                buffer
//
//  One byte per cycle while i_in is ready. A byte takes effect in the capture
//  registers at the edge that transfers it; the verdict of a flagged byte is
//  loaded into the output register at that same edge and can transfer from
//  the next edge on. The rate is set by the capture counter plus one 17-bit
//  end-around-carry add per byte.
//  Reset (i_rst_n low, synchronous) clears the capture state and the output
//  valid. o_out stalling holds the verdict; i_in stays ready while the output
//  register is empty or being drained in the same cycle.
//
module ipv4_header_checker_unit #(
    parameter int MAX_BUFFER_BYTES = ihc_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ihc_in_if.sink    i_in,
    ihc_out_if.source o_out
);
    import ihc_pkg::*;

    logic    take;          // byte transfer on i_in
    t_hdr    hdr_next;      // header state including the byte now taken
    t_result result_next;   // verdict if this byte closes the buffer

    logic    r_valid;
    t_result r_result;

    // Ready unless a verdict is waiting and not being taken this cycle.
    assign i_in.ready = !r_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    ihc_capture #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_hdr       (hdr_next)
    );

    ihc_classify u_classify (
        .i_hdr    (hdr_next),
        .o_result (result_next)
    );

    // Output register: valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take && i_in.last_byte) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in.last_byte) begin
            r_result <= result_next;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.verdict       = r_result.verdict;
    assign o_out.deliver_to    = r_result.deliver_to;
    assign o_out.protocol      = r_result.protocol;
    assign o_out.source_addr   = r_result.source_addr;
    assign o_out.dest_addr     = r_result.dest_addr;
    assign o_out.header_bytes  = r_result.header_bytes;
    assign o_out.payload_bytes = r_result.payload_bytes;

`ifndef ASSERT_OFF
    // A flagged byte always yields a verdict on the next cycle.
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in.last_byte) |=> r_valid)
        else $error("flagged byte produced no verdict");

    // Delivery class is only given for accepted buffers.
    a_deliver_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_result.deliver_to != DLV_NONE)) |-> (r_result.verdict == V_ACCEPT))
        else $error("delivery class on a rejected buffer");

    // Payload length is zero on every rejection.
    a_payload_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_result.verdict != V_ACCEPT)) |-> (r_result.payload_bytes == 16'd0))
        else $error("payload length on a rejected buffer");

    // A verdict that is not taken holds.
    a_verdict_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> (r_valid && $stable(r_result)))
        else $error("stalled verdict changed");
`endif

endmodule

FILE: rtl/ihc_capture.sv
// ----------------------------------------------------------------------------
// ihc_capture
// Byte counter, header field capture and running one's-complement sum.
// ----------------------------------------------------------------------------
module ihc_capture #(
    parameter int MAX_BUFFER_BYTES = ihc_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output ihc_pkg::t_hdr o_hdr
);
    import ihc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUFFER_BYTES);

    logic [CNT_W-1:0] r_byte_index,   n_byte_index;
    logic [7:0]       r_version_ihl,  n_version_ihl;
    logic [15:0]      r_total_length, n_total_length;
    logic [15:0]      r_fragment_word, n_fragment_word;
    logic [7:0]       r_proto_byte,   n_proto_byte;
    logic [31:0]      r_src_word,     n_src_word;
    logic [31:0]      r_dst_word,     n_dst_word;
    logic [7:0]       r_high_byte_hold, n_high_byte_hold;
    logic [15:0]      r_ones_sum,     n_ones_sum;

    logic [5:0]       hlen;
    logic [16:0]      sum_wide;

    always_comb begin
        n_byte_index     = r_byte_index;
        n_version_ihl    = r_version_ihl;
        n_total_length   = r_total_length;
        n_fragment_word  = r_fragment_word;
        n_proto_byte     = r_proto_byte;
        n_src_word       = r_src_word;
        n_dst_word       = r_dst_word;
        n_high_byte_hold = r_high_byte_hold;
        n_ones_sum       = r_ones_sum;
        hlen             = {r_version_ihl[3:0], 2'b00};
        sum_wide         = {1'b0, r_ones_sum} + {1'b0, r_high_byte_hold, i_data_byte};

        // bytes past the limit are not counted or captured; a flagged one still closes the buffer
        if (i_take && (r_byte_index < CNT_MAX)) begin
            n_byte_index = r_byte_index + CNT_W'(1);

            case (r_byte_index)
                CNT_W'(POS_VER_IHL): n_version_ihl = i_data_byte;
                CNT_W'(POS_TLEN_HI): n_total_length = {i_data_byte, r_total_length[7:0]};
                CNT_W'(POS_TLEN_LO): n_total_length = {r_total_length[15:8], i_data_byte};
                CNT_W'(POS_FRAG_HI): n_fragment_word = {i_data_byte, r_fragment_word[7:0]};
                CNT_W'(POS_FRAG_LO): n_fragment_word = {r_fragment_word[15:8], i_data_byte};
                CNT_W'(POS_PROTO):   n_proto_byte = i_data_byte;
                default: ;
            endcase

            if ((r_byte_index >= CNT_W'(POS_SRC_FIRST)) &&
                (r_byte_index <  CNT_W'(POS_DST_FIRST))) begin
                n_src_word = {r_src_word[23:0], i_data_byte};
            end else if ((r_byte_index >= CNT_W'(POS_DST_FIRST)) &&
                         (r_byte_index <  CNT_W'(POS_DST_END))) begin
                n_dst_word = {r_dst_word[23:0], i_data_byte};
            end

            // header length includes this byte's IHL when it is byte 0
            hlen = {n_version_ihl[3:0], 2'b00};
            if (LEN_W'(r_byte_index) < LEN_W'(hlen)) begin
                if (!r_byte_index[0]) begin
                    n_high_byte_hold = i_data_byte;
                end else begin
                    // end-around carry
                    n_ones_sum = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last_byte)) begin
            r_byte_index     <= '0;
            r_version_ihl    <= '0;
            r_total_length   <= '0;
            r_fragment_word  <= '0;
            r_proto_byte     <= '0;
            r_src_word       <= '0;
            r_dst_word       <= '0;
            r_high_byte_hold <= '0;
            r_ones_sum       <= '0;
        end else begin
            r_byte_index     <= n_byte_index;
            r_version_ihl    <= n_version_ihl;
            r_total_length   <= n_total_length;
            r_fragment_word  <= n_fragment_word;
            r_proto_byte     <= n_proto_byte;
            r_src_word       <= n_src_word;
            r_dst_word       <= n_dst_word;
            r_high_byte_hold <= n_high_byte_hold;
            r_ones_sum       <= n_ones_sum;
        end
    end

    always_comb begin
        o_hdr.len           = LEN_W'(n_byte_index);
        o_hdr.version_ihl   = n_version_ihl;
        o_hdr.total_length  = n_total_length;
        o_hdr.fragment_word = n_fragment_word;
        o_hdr.proto_byte    = n_proto_byte;
        o_hdr.src_word      = n_src_word;
        o_hdr.dst_word      = n_dst_word;
        o_hdr.ones_sum      = n_ones_sum;
    end

endmodule

FILE: rtl/ihc_classify.sv
// ----------------------------------------------------------------------------
// ihc_classify
// Ordered header checks and protocol class for a completed buffer.
// ----------------------------------------------------------------------------
module ihc_classify (
    input  ihc_pkg::t_hdr    i_hdr,
    output ihc_pkg::t_result o_result
);
    import ihc_pkg::*;

    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [5:0]  hlen;
    logic [15:0] hlen_ext;

    always_comb begin
        ver      = i_hdr.version_ihl[7:4];
        ihl      = i_hdr.version_ihl[3:0];
        hlen     = {ihl, 2'b00};
        hlen_ext = 16'(hlen);

        o_result.verdict       = V_ACCEPT;
        o_result.deliver_to    = DLV_NONE;
        o_result.protocol      = i_hdr.proto_byte;
        o_result.source_addr   = i_hdr.src_word;
        o_result.dest_addr     = i_hdr.dst_word;
        o_result.header_bytes  = hlen;
        o_result.payload_bytes = '0;

        if (i_hdr.len < LEN_W'(MIN_HDR_BYTES)) begin
            o_result.verdict = V_TOO_SHORT;
        end else if ((ver != IP_VERSION) || (ihl < IHL_MIN)) begin
            o_result.verdict = V_BAD_HDR;
        end else if (LEN_W'(hlen) > i_hdr.len) begin
            o_result.verdict = V_TOO_SHORT;
        end else if ((i_hdr.total_length < hlen_ext) ||
                     (i_hdr.total_length > 16'(i_hdr.len))) begin
            o_result.verdict = V_BAD_LEN;
        end else if (i_hdr.ones_sum != SUM_GOOD) begin
            o_result.verdict = V_BAD_SUM;
        end else if ((i_hdr.fragment_word & FRAG_MASK) != 16'd0) begin
            o_result.verdict = V_FRAGMENT;
        end else begin
            o_result.payload_bytes = i_hdr.total_length - hlen_ext;
            case (i_hdr.proto_byte)
                PROTO_ICMP: o_result.deliver_to = DLV_ICMP;
                PROTO_UDP:  o_result.deliver_to = DLV_UDP;
                PROTO_TCP:  o_result.deliver_to = DLV_TCP;
                default:    o_result.deliver_to = DLV_NONE;
            endcase
        end
    end

endmodule
